// ----- hw/rtl/utf8dc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8dc_pkg
// Types, constants and the lead byte table of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8dc_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned BYTE_W = 8;

  // Longest string handled; byte offsets saturate below it.
  localparam logic [32:0] MAX_BYTES  = 33'd65536;
  localparam logic [15:0] OFFSET_CAP = ((MAX_BYTES - 33'd1) < 33'd65535) ?
                                       16'(MAX_BYTES - 33'd1) : 16'hFFFF;
  localparam logic [15:0] INDEX_CAP  = 16'hFFFF;

  localparam logic [CP_W-1:0]   REPLACEMENT = 21'h00FFFD;
  localparam logic [BYTE_W-1:0] CONT_MASK   = 8'd63;
  localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'd31;
  localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'd15;
  localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'd7;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_COUNT = 1'b1;

  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  typedef struct packed {
    logic             kind;
    logic [CP_W-1:0]  codepoint;
    logic [IDX_W-1:0] char_index;
    logic [IDX_W-1:0] byte_offset;
    logic [IDX_W-1:0] char_count;
    logic [IDX_W-1:0] view_offset;
    logic [IDX_W-1:0] view_size;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [1:0]       rem;
    logic [CP_W-1:0]  acc;
    logic [IDX_W-1:0] cso;
    logic [IDX_W-1:0] byte_cnt;
    logic [IDX_W-1:0] char_cnt;
    logic [IDX_W-1:0] vbo;
    logic [IDX_W-1:0] veo;
    logic [1:0]       vflags;   // bit 0 view begun, bit 1 view ended
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] view_start;
    logic [IDX_W-1:0] view_count;
  } cfg_t;

  function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [2:0] len;
    if (b < 8'h80)      len = LEN_1;
    else if (b < 8'hC2) len = LEN_BAD;
    else if (b < 8'hE0) len = LEN_2;
    else if (b < 8'hF0) len = LEN_3;
    else if (b < 8'hF5) len = LEN_4;
    else                len = LEN_BAD;
    return len;
  endfunction

endpackage

// ----- hw/rtl/utf8_decode_count_substring_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_count_substring_core
// UTF-8 byte stream decoder with character count and substring view window.
//
//   channel  dir  handshake           words
//   in_      in   in_valid/in_stall   one string byte
//   out_     out  out_valid/out_stall decoded character or end summary
//   cfg_     in   cfg_we              view_start, view_count
//
// One byte is taken per cycle while in_stall is low; its results are written
// to a four-entry queue at the same edge and are read from its head on out_.
// A byte makes at most one word, except a terminator after a truncated
// character, which makes two.
// in_stall is high while the queue holds three or more words.
// Reset is synchronous; it clears the string state and the queue and sets
// view_start to 0 and view_count to 1.
// ----------------------------------------------------------------------------
module utf8_decode_count_substring_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [utf8dc_pkg::BYTE_W-1:0]       in_byte_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_kind,
  output logic [utf8dc_pkg::CP_W-1:0]         out_codepoint,
  output logic [utf8dc_pkg::IDX_W-1:0]        out_char_index,
  output logic [utf8dc_pkg::IDX_W-1:0]        out_byte_offset,
  output logic [utf8dc_pkg::IDX_W-1:0]        out_char_count,
  output logic [utf8dc_pkg::IDX_W-1:0]        out_view_offset,
  output logic [utf8dc_pkg::IDX_W-1:0]        out_view_size,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [utf8dc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [utf8dc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import utf8dc_pkg::*;

  cfg_t       cfg_r;
  state_t     st_r;
  state_t     st_nxt;
  result_t    res0;
  result_t    res1;
  result_t    head;
  logic [1:0] nres;
  logic [1:0] push_n;
  logic       in_acc;
  logic       out_pop;
  logic       q_not_empty;
  logic       q_room2;
  logic [2:0] q_cnt;

  assign in_stall = !q_room2;
  assign in_acc   = in_valid && !in_stall;
  assign out_pop  = q_not_empty && !out_stall;
  assign push_n   = in_acc ? nres : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.view_start <= '0;
      cfg_r.view_count <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VIEW_START: cfg_r.view_start <= cfg_wdata;
        CFG_VIEW_COUNT: cfg_r.view_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  utf8dc_step u_step (
    .st      (st_r),
    .cfg     (cfg_r),
    .byte_in (in_byte_in),
    .st_nxt  (st_nxt),
    .res0    (res0),
    .res1    (res1),
    .nres    (nres)
  );

  utf8dc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .pop       (out_pop),
    .head      (head),
    .not_empty (q_not_empty),
    .room2     (q_room2),
    .count     (q_cnt)
  );

  assign out_valid       = q_not_empty;
  assign out_kind        = head.kind;
  assign out_codepoint   = head.codepoint;
  assign out_char_index  = head.char_index;
  assign out_byte_offset = head.byte_offset;
  assign out_char_count  = head.char_count;
  assign out_view_offset = head.view_offset;
  assign out_view_size   = head.view_size;
  assign out_last        = head.last;

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= 3'd4)
    else $error("result queue overfilled");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_byte_in == '0 |=> st_r == '0)
    else $error("string state not cleared after terminator");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc && out_pop |=> q_cnt == $past(q_cnt) - 3'd1)
    else $error("queue count wrong on pop");

  a_cont_after_lead: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.rem != 2'd0 |-> st_r.byte_cnt >= st_r.cso && st_r.byte_cnt != '0)
    else $error("pending character without its lead byte");

endmodule

// ----- hw/rtl/utf8dc_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8dc_step
// Per-byte decode: next string state and up to two result words.
// ----------------------------------------------------------------------------
module utf8dc_step (
  input  utf8dc_pkg::state_t                   st,
  input  utf8dc_pkg::cfg_t                     cfg,
  input  logic [utf8dc_pkg::BYTE_W-1:0]        byte_in,
  output utf8dc_pkg::state_t                   st_nxt,
  output utf8dc_pkg::result_t                  res0,
  output utf8dc_pkg::result_t                  res1,
  output logic [1:0]                           nres
);
  import utf8dc_pkg::*;

  logic [IDX_W-1:0] cc_inc;
  logic [IDX_W-1:0] bc_inc;
  logic [IDX_W:0]   view_end_idx;
  logic [IDX_W-1:0] cnt_fin;
  logic [IDX_W-1:0] begin_off;
  logic [IDX_W-1:0] end_off;
  logic [CP_W-1:0]  acc_new;
  logic [2:0]       lead_len;
  result_t          summ;

  assign cc_inc       = (st.char_cnt != INDEX_CAP) ? st.char_cnt + 16'd1 : st.char_cnt;
  assign bc_inc       = (st.byte_cnt < OFFSET_CAP) ? st.byte_cnt + 16'd1 : st.byte_cnt;
  assign view_end_idx = {1'b0, cfg.view_start} + {1'b0, cfg.view_count};
  assign acc_new      = {st.acc[CP_W-7:0], byte_in[5:0] & CONT_MASK[5:0]};
  assign lead_len     = lead_length(byte_in);

  always_comb begin
    st_nxt    = st;
    res0      = '0;
    res1      = '0;
    nres      = 2'd0;
    cnt_fin   = st.char_cnt;
    begin_off = st.vflags[0] ? st.vbo : st.byte_cnt;
    end_off   = st.vflags[1] ? st.veo : st.byte_cnt;
    summ      = '0;

    if (byte_in == '0) begin
      // terminator: flush a truncated character, then the summary
      if (st.rem != 2'd0) begin
        res0.kind        = KIND_CHAR;
        res0.codepoint   = REPLACEMENT;
        res0.char_index  = st.char_cnt;
        res0.byte_offset = st.cso;
        cnt_fin          = cc_inc;
      end
      if (end_off < begin_off) end_off = begin_off;
      summ.kind        = KIND_SUMMARY;
      summ.byte_offset = st.byte_cnt;
      summ.char_count  = cnt_fin;
      summ.view_offset = begin_off;
      summ.view_size   = end_off - begin_off;
      summ.last        = 1'b1;
      if (st.rem != 2'd0) begin
        res1 = summ;
        nres = 2'd2;
      end else begin
        res0 = summ;
        nres = 2'd1;
      end
      st_nxt = '0;
    end else if (st.rem != 2'd0) begin
      st_nxt.acc      = acc_new;
      st_nxt.rem      = st.rem - 2'd1;
      st_nxt.byte_cnt = bc_inc;
      if (st.rem == 2'd1) begin
        res0.kind        = KIND_CHAR;
        res0.codepoint   = acc_new;
        res0.char_index  = st.char_cnt;
        res0.byte_offset = st.cso;
        nres             = 2'd1;
        st_nxt.char_cnt  = cc_inc;
      end
    end else begin
      if (!st.vflags[0] && st.char_cnt == cfg.view_start) begin
        st_nxt.vbo       = st.byte_cnt;
        st_nxt.vflags[0] = 1'b1;
      end
      if (!st.vflags[1] && {1'b0, st.char_cnt} == view_end_idx) begin
        st_nxt.veo       = st.byte_cnt;
        st_nxt.vflags[1] = 1'b1;
      end
      st_nxt.byte_cnt = bc_inc;
      case (lead_len)
        LEN_1: begin
          res0.kind        = KIND_CHAR;
          res0.codepoint   = CP_W'(byte_in);
          res0.char_index  = st.char_cnt;
          res0.byte_offset = st.byte_cnt;
          nres             = 2'd1;
          st_nxt.char_cnt  = cc_inc;
        end
        LEN_2: begin
          st_nxt.acc = CP_W'(byte_in & LEAD2_MASK);
          st_nxt.rem = 2'd1;
          st_nxt.cso = st.byte_cnt;
        end
        LEN_3: begin
          st_nxt.acc = CP_W'(byte_in & LEAD3_MASK);
          st_nxt.rem = 2'd2;
          st_nxt.cso = st.byte_cnt;
        end
        LEN_4: begin
          st_nxt.acc = CP_W'(byte_in & LEAD4_MASK);
          st_nxt.rem = 2'd3;
          st_nxt.cso = st.byte_cnt;
        end
        default: begin
          res0.kind        = KIND_CHAR;
          res0.codepoint   = REPLACEMENT;
          res0.char_index  = st.char_cnt;
          res0.byte_offset = st.byte_cnt;
          nres             = 2'd1;
          st_nxt.char_cnt  = cc_inc;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/utf8dc_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8dc_outq
// Four-entry result queue; takes up to two words a cycle, gives one.
// ----------------------------------------------------------------------------
module utf8dc_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_n,
  input  utf8dc_pkg::result_t  push0,
  input  utf8dc_pkg::result_t  push1,
  input  logic                 pop,
  output utf8dc_pkg::result_t  head,
  output logic                 not_empty,
  output logic                 room2,
  output logic [2:0]           count
);
  import utf8dc_pkg::*;

  result_t    q_r [4];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign head      = q_r[rp_r];
  assign not_empty = (cnt_r != 3'd0);
  assign room2     = (cnt_r <= 3'd2);
  assign count     = cnt_r;

  assign wp_nxt  = wp_r + push_n;
  assign rp_nxt  = rp_r + {1'b0, pop};
  assign cnt_nxt = cnt_r + {1'b0, push_n} - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wp_r] <= push0;
    end
    if (push_n == 2'd2) begin
      q_r[wp_r + 2'd1] <= push1;
    end
  end

endmodule
